@@ src/wgm_pkg.sv @@
`timescale 1ns / 1ps

package wgm_pkg;

    // Pattern metacharacters
    localparam logic [7:0] GLOB_STAR = 8'h2A;
    localparam logic [7:0] GLOB_ONE  = 8'h3F;

    typedef enum logic [1:0] {
        KIND_APPEND  = 2'd0,
        KIND_CLEAR   = 2'd1,
        KIND_SUBJECT = 2'd2,
        KIND_END     = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] symbol;
    } t_in_beat;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_out_beat;

    // Shared controls broadcast to every cell
    typedef struct packed {
        logic clear;    // drop the stored pattern
        logic step;     // advance the active set by one subject byte
        logic restart;  // active set back to position zero only
    } t_cell_ctrl;

    // What a cell reports to the row
    typedef struct packed {
        logic act;      // raw active bit of this position
        logic prop;     // position holds a '*' inside the pattern
        logic fwd;      // this position matched the byte; next position goes active
    } t_cell_status;

endpackage

@@ src/wgm_cell.sv @@
`timescale 1ns / 1ps

module wgm_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wgm_pkg::t_cell_ctrl   i_ctrl,
    input  logic                  i_load,
    input  logic [7:0]            i_symbol,
    input  logic                  i_home,
    input  logic                  i_closed,
    input  logic                  i_fwd,
    output wgm_pkg::t_cell_status o_status
);

    logic       r_used;
    logic       r_act;
    logic [7:0] r_byte;
    logic       n_used;
    logic       n_act;
    logic       w_star;

    assign w_star = r_used && (r_byte == wgm_pkg::GLOB_STAR);

    always_comb begin
        n_used = r_used;
        if (i_ctrl.clear) begin
            n_used = 1'b0;
        end else if (i_load) begin
            n_used = 1'b1;
        end
    end

    // A star keeps its own position; a literal or '?' hit arrives from the left neighbor
    always_comb begin
        n_act = r_act;
        if (i_ctrl.restart) begin
            n_act = i_home;
        end else if (i_ctrl.step) begin
            n_act = (i_closed && w_star) || i_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_act  <= i_home;
        end else begin
            r_used <= n_used;
            r_act  <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_symbol;
        end
    end

    assign o_status.act  = r_act;
    assign o_status.prop = w_star;
    assign o_status.fwd  = i_closed && r_used && !w_star
                           && ((r_byte == wgm_pkg::GLOB_ONE) || (r_byte == i_symbol));

endmodule

@@ src/wgm_closure.sv @@
`timescale 1ns / 1ps

// Star closure: an active position on a '*' lights the next one, through whole runs.
// Done as one add: generate where a star is active, propagate where a star is idle.
module wgm_closure #(
    parameter int WIDTH = 33
) (
    input  logic [WIDTH-1:0] i_raw,
    input  logic [WIDTH-1:0] i_prop,
    output logic [WIDTH-1:0] o_closed
);

    logic [WIDTH-1:0] w_gen;
    logic [WIDTH-1:0] w_sum;
    logic [WIDTH-1:0] w_carry;

    assign w_gen    = i_prop & i_raw;
    assign w_sum    = i_prop + w_gen;
    assign w_carry  = w_sum ^ i_prop ^ w_gen;
    assign o_closed = i_raw | w_carry;

endmodule

@@ src/wildcard_glob_matcher.sv @@
`timescale 1ns / 1ps
// Result: an accepted end-of-subject beat is registered into the output register, or into the skid entry if held.
// Throughput: one beat per cycle, any kind, while o_in_stall is low; the row of cells advances every subject byte.
// The closure add feeding the row is the critical path, one adder of PATTERN_MAX+1 bits.
// Reset (synchronous, active low): empty pattern, overflow clear, position zero active,
// no result pending. Pattern bytes themselves are not cleared.

module wildcard_glob_matcher #(
    parameter int PATTERN_MAX = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  wgm_pkg::t_in_beat   i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output wgm_pkg::t_out_beat  o_out_data,
    input  logic                i_out_stall
);

    localparam int LW = $clog2(PATTERN_MAX + 1);

    // Length of the loaded pattern, doubles as the write pointer
    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic          r_ovf;
    logic          n_ovf;
    // Raw active bit of the position past the last cell
    logic          r_end_act;
    logic          n_end_act;

    // Output register plus one skid entry
    logic                r_out_valid;
    logic                n_out_valid;
    wgm_pkg::t_out_beat  r_out_data;
    wgm_pkg::t_out_beat  n_out_data;
    logic                r_skid_valid;
    logic                n_skid_valid;
    wgm_pkg::t_out_beat  r_skid_data;
    wgm_pkg::t_out_beat  n_skid_data;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_append;
    logic                  w_res_valid;
    logic                  w_out_take;
    wgm_pkg::t_out_beat    w_res;
    wgm_pkg::t_cell_ctrl   w_ctrl;
    wgm_pkg::t_cell_status w_status [PATTERN_MAX];
    logic [PATTERN_MAX:0]  w_raw;
    logic [PATTERN_MAX:0]  w_prop;
    logic [PATTERN_MAX:0]  w_closed;

    // Skid full means the output side is backed up by two beats
    assign o_in_stall = r_skid_valid;
    assign w_accept   = i_in_valid && !r_skid_valid;
    assign w_full     = (r_len == LW'(PATTERN_MAX));

    always_comb begin
        w_append     = 1'b0;
        w_ctrl       = '0;
        w_res_valid  = 1'b0;
        if (w_accept) begin
            case (i_in_data.kind)
                wgm_pkg::KIND_APPEND: begin
                    w_append = 1'b1;
                end
                wgm_pkg::KIND_CLEAR: begin
                    w_ctrl.clear   = 1'b1;
                    w_ctrl.restart = 1'b1;
                end
                wgm_pkg::KIND_SUBJECT: begin
                    w_ctrl.step = 1'b1;
                end
                wgm_pkg::KIND_END: begin
                    w_ctrl.restart = 1'b1;
                    w_res_valid    = 1'b1;
                end
                default: begin
                    w_append = 1'b0;
                end
            endcase
        end
    end

    // Row of cells, one per pattern position; match hits ripple one cell right per byte
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        logic w_left_fwd;
        logic w_load;

        if (i == 0) begin : g_head
            assign w_left_fwd = 1'b0;
        end else begin : g_body
            assign w_left_fwd = w_status[i-1].fwd;
        end

        assign w_load = w_append && !w_full && (r_len == LW'(i));

        wgm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_load   (w_load),
            .i_symbol (i_in_data.symbol),
            .i_home   (1'(i == 0)),
            .i_closed (w_closed[i]),
            .i_fwd    (w_left_fwd),
            .o_status (w_status[i])
        );

        assign w_raw[i]  = w_status[i].act;
        assign w_prop[i] = w_status[i].prop;
    end

    assign w_raw[PATTERN_MAX]  = r_end_act;
    assign w_prop[PATTERN_MAX] = 1'b0;

    // Closure is taken against the pattern as it stands now
    wgm_closure #(
        .WIDTH (PATTERN_MAX + 1)
    ) u_closure (
        .i_raw    (w_raw),
        .i_prop   (w_prop),
        .o_closed (w_closed)
    );

    assign w_res.matched          = w_closed[r_len];
    assign w_res.pattern_overflow = r_ovf;

    always_comb begin
        n_len     = r_len;
        n_ovf     = r_ovf;
        n_end_act = r_end_act;
        if (w_ctrl.clear) begin
            n_len = '0;
            n_ovf = 1'b0;
        end else if (w_append) begin
            if (w_full) begin
                n_ovf = 1'b1;       // extra bytes are dropped
            end else begin
                n_len = r_len + LW'(1);
            end
        end
        if (w_ctrl.restart) begin
            n_end_act = 1'b0;
        end else if (w_ctrl.step) begin
            n_end_act = w_status[PATTERN_MAX-1].fwd;
        end
    end

    // Result beat goes to the output register when it is free or draining, else to skid
    assign w_out_take = r_out_valid && !i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (w_out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else if (w_res_valid) begin
                n_out_valid = 1'b1;
                n_out_data  = w_res;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (w_res_valid) begin
            n_skid_valid = 1'b1;
            n_skid_data  = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= '0;
            r_ovf        <= 1'b0;
            r_end_act    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_len        <= n_len;
            r_ovf        <= n_ovf;
            r_end_act    <= n_end_act;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Skid only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while output register is empty");

    // Pattern length stays within the row
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(PATTERN_MAX))
        else $error("pattern length past capacity");

    // End of subject leaves only position zero active
    a_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.kind == wgm_pkg::KIND_END)
        |=> (w_raw == (PATTERN_MAX + 1)'(1)))
        else $error("active set not restarted after end of subject");

    // Clear drops the pattern and the overflow flag
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.kind == wgm_pkg::KIND_CLEAR)
        |=> (r_len == '0) && !r_ovf)
        else $error("clear did not empty the pattern");

endmodule
